// File: rtl/core/hsd_pkg.sv
// Shared widths, result flag type and constant position tables for the
// Hamming syndrome decoder. No dependencies.
package hsd_pkg;

    localparam int WORD_W                = 63;
    localparam int DATA_W                = 57;
    localparam int SYN_W                 = 6;
    localparam int DEFAULT_MAX_CODE_BITS = 63;
    localparam int RESET_LENGTH          = 7;

    typedef struct packed {
        logic error_found;
        logic uncorrectable;
    } hsd_flags_t;

    // Positions (1-based) whose bit b is set, as a mask over word bits.
    function automatic logic [WORD_W-1:0] syn_mask(input int b);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            m[i] = (((i + 1) >> b) & 1) != 0;
        end
        return m;
    endfunction

    // Word bit that holds the k-th data bit (non-power-of-two positions).
    function automatic logic [SYN_W-1:0] data_index(input int k);
        int                cnt;
        logic [SYN_W-1:0]  idx;
        cnt = 0;
        idx = '0;
        for (int p = 1; p <= WORD_W; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                if (cnt == k)
                    idx = SYN_W'(p - 1);
                cnt++;
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/core/hsd_core.sv
// Combinational decode of one codeword: mask, syndrome, single-bit fix
// and data extraction. Depends on hsd_pkg.
module hsd_core (
    input  logic [hsd_pkg::SYN_W-1:0]  code_length,
    input  logic [hsd_pkg::WORD_W-1:0] word,
    output logic [hsd_pkg::SYN_W-1:0]  syndrome,
    output hsd_pkg::hsd_flags_t        flags,
    output logic [hsd_pkg::WORD_W-1:0] corrected_word,
    output logic [hsd_pkg::DATA_W-1:0] data_out
);
    import hsd_pkg::*;

    logic [WORD_W-1:0] used_word;
    logic [WORD_W-1:0] flip_vec;
    logic              in_range;

    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            used_word[i] = word[i] && (SYN_W'(i) < code_length);
        end
        for (int b = 0; b < SYN_W; b++)
        begin
            syndrome[b] = ^(used_word & syn_mask(b));
        end
        in_range = (syndrome != '0) && (syndrome <= code_length);
        flags.error_found   = (syndrome != '0);
        flags.uncorrectable = (syndrome != '0) && !in_range;
        for (int i = 0; i < WORD_W; i++)
        begin
            flip_vec[i] = in_range && (syndrome == SYN_W'(i + 1));
        end
        corrected_word = used_word ^ flip_vec;
    end

    for (genvar k = 0; k < DATA_W; k++)
    begin : g_data
        assign data_out[k] = corrected_word[data_index(k)];
    end

endmodule

// File: rtl/core/hamming_syndrome_decoder.sv
// Top level of the Hamming single-error-correcting decoder: input register,
// decode logic, result register and length register. Depends on hsd_pkg, hsd_core.
//
// Accepts one received codeword per cycle unless word_stall is high and
// returns one result per word, through the input and result registers. The rate
// is set by the two-register pipeline (input register, then the result
// register after a single pass through hsd_core); a full pipeline keeps
// taking words whenever the result side takes results. code_length is
// clamped to MAX_CODE_BITS on write and must be changed only while idle.
module hamming_syndrome_decoder #(
    parameter int MAX_CODE_BITS = hsd_pkg::DEFAULT_MAX_CODE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hsd_pkg::SYN_W-1:0]   cfg_wdata,
    input  logic                        word_valid,
    output logic                        word_stall,
    input  logic [hsd_pkg::WORD_W-1:0]  received_word,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [hsd_pkg::SYN_W-1:0]   syndrome,
    output logic                        error_found,
    output logic                        uncorrectable,
    output logic [hsd_pkg::WORD_W-1:0]  corrected_word,
    output logic [hsd_pkg::DATA_W-1:0]  data_out
);
    import hsd_pkg::*;

    localparam logic [SYN_W-1:0] MAX_LEN   = SYN_W'(MAX_CODE_BITS);
    localparam logic [SYN_W-1:0] RESET_LEN =
        (RESET_LENGTH > MAX_CODE_BITS) ? SYN_W'(MAX_CODE_BITS) : SYN_W'(RESET_LENGTH);

    logic [SYN_W-1:0]  length_reg;
    logic [SYN_W-1:0]  length_next;
    logic              s1_valid_reg;
    logic [WORD_W-1:0] s1_word_reg;
    logic              out_valid_reg;
    logic [SYN_W-1:0]  syn_reg;
    hsd_flags_t        flags_reg;
    logic [WORD_W-1:0] corr_reg;
    logic [DATA_W-1:0] data_reg;

    logic              adv_out;
    logic              adv_s1;
    logic [SYN_W-1:0]  syn_next;
    hsd_flags_t        flags_next;
    logic [WORD_W-1:0] corr_next;
    logic [DATA_W-1:0] data_next;

    assign length_next = (cfg_wdata > MAX_LEN) ? MAX_LEN : cfg_wdata;
    assign adv_out     = !out_valid_reg || !result_stall;
    assign adv_s1      = !s1_valid_reg || adv_out;
    assign word_stall  = !adv_s1;

    hsd_core u_core (
        .code_length    (length_reg),
        .word           (s1_word_reg),
        .syndrome       (syn_next),
        .flags          (flags_next),
        .corrected_word (corr_next),
        .data_out       (data_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= RESET_LEN;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                length_reg <= length_next;
            if (adv_s1)
                s1_valid_reg <= word_valid;
            if (adv_out)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // hold payload while stalled, advance otherwise
    always_ff @(posedge clk)
    begin
        if (adv_s1 && word_valid)
            s1_word_reg <= received_word;
        if (adv_out && s1_valid_reg)
        begin
            syn_reg   <= syn_next;
            flags_reg <= flags_next;
            corr_reg  <= corr_next;
            data_reg  <= data_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign syndrome       = syn_reg;
    assign error_found    = flags_reg.error_found;
    assign uncorrectable  = flags_reg.uncorrectable;
    assign corrected_word = corr_reg;
    assign data_out       = data_reg;

`ifndef SYNTHESIS
    a_uncorr_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!flags_reg.uncorrectable || flags_reg.error_found))
        else $error("uncorrectable request without error flag");

    a_error_matches_syn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (flags_reg.error_found == (syn_reg != '0)))
        else $error("error flag disagrees with syndrome");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv_out) |=> out_valid_reg)
        else $error("request lost between stages");

    a_length_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= MAX_LEN)
        else $error("code length above maximum");
`endif

endmodule
